// File: src/fcc_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain package
// Shared types and constants for the cluster chain lookup block.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // Result status codes
    localparam logic [2:0] ST_WRITE    = 3'd0;
    localparam logic [2:0] ST_DATA     = 3'd1;
    localparam logic [2:0] ST_BAD      = 3'd2;
    localparam logic [2:0] ST_END      = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_BYTES_PER_SECTOR    = 3'd0;
    localparam logic [2:0] CFG_SECTORS_PER_CLUSTER = 3'd1;
    localparam logic [2:0] CFG_RESERVED_SECTORS    = 3'd2;
    localparam logic [2:0] CFG_SECTORS_PER_FAT     = 3'd3;
    localparam logic [2:0] CFG_FAT_COPIES          = 3'd4;
    localparam logic [2:0] CFG_ROOT_ENTRY_COUNT    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [11:0] CLUSTER_BAD       = 12'hFF7;
    localparam logic [11:0] CLUSTER_END_FIRST = 12'hFF8;
    localparam logic [11:0] CLUSTER_FIRST     = 12'd2;

    // One classified item travelling from the front end to the back end.
    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] idx;
        logic [7:0]  val;
        logic [12:0] pos;
        logic        odd;
        logic [11:0] offset;
    } cmd_t;

    // Volume geometry derived from the configuration registers.
    typedef struct packed {
        logic [20:0] cluster_bytes;
        logic [31:0] data_start;
    } geom_t;

endpackage

// File: src/fat12_cluster_chain_step.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain step
// Keeps a byte copy of a FAT12 table and, for a followed cluster, returns
// its byte address in the volume image and the next cluster of the chain.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while in_ready is high and returns
// one result per transaction: the command is held in the queue, then the table
// read and the address multiply load the stage-one registers before the result
// register loads; an output stall holds results back. The table sits in two
// byte-wide RAM banks (even and odd byte positions), so both bytes of an entry
// are read at once. After reset and after every configuration write, in_ready
// stays low while the geometry unit recomputes the data region start; the root
// directory sector count comes from a bit-serial divider that resolves one of
// 21 quotient bits per cycle.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_step
    import fcc_pkg::*;
#(
    parameter int FAT_BYTES = 8192
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [12:0]            table_byte_index,
    input  logic [7:0]             table_byte_value,
    input  logic [11:0]            cluster,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             status,
    output logic [31:0]            cluster_address,
    output logic [11:0]            next_cluster
);

    logic  busy;
    geom_t geom;
    logic  q_ready;
    logic  push;
    cmd_t  push_cmd;
    logic  pop;
    logic  head_valid;
    cmd_t  head_cmd;

    fcc_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .geom      (geom)
    );

    fcc_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .table_byte_index (table_byte_index),
        .table_byte_value (table_byte_value),
        .cluster          (cluster),
        .busy             (busy),
        .q_ready          (q_ready),
        .push             (push),
        .cmd              (push_cmd)
    );

    fcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    fcc_back #(
        .FAT_BYTES (FAT_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .geom            (geom),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .cluster_address (cluster_address),
        .next_cluster    (next_cluster)
    );

endmodule

// File: src/fcc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/fcc_geom.sv
// ----------------------------------------------------------------------------
// FAT12 geometry unit
// Holds the configuration registers and derives the data region start and
// the cluster size in bytes, using a bit-serial divider for the root
// directory sector count.
// ----------------------------------------------------------------------------
module fcc_geom
    import fcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   busy,
    output geom_t                  geom
);

    localparam int NUM_W    = 21;
    localparam int DIV_STEPS = NUM_W;

    typedef enum logic [2:0] {
        G_LOAD,
        G_DIV,
        G_SUM,
        G_MUL,
        G_IDLE
    } gstate_t;

    gstate_t     state_reg;
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] res_reg;
    logic [15:0] spf_reg;
    logic [2:0]  copies_reg;
    logic [15:0] rec_reg;

    logic [13:0]      rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [4:0]       cnt_reg;
    logic [21:0]      sum_reg;
    logic [20:0]      cluster_bytes_reg;
    logic [31:0]      data_start_reg;

    logic [13:0]      rem_shift;
    logic [13:0]      rem_next;
    logic             qbit;
    logic [21:0]      root_secs;
    logic [21:0]      sum_next;

    // One restoring division step per cycle.
    always_comb
    begin
        rem_shift = {rem_reg[12:0], quot_reg[NUM_W-1]};
        qbit      = (rem_shift >= {1'b0, bps_reg});
        rem_next  = qbit ? (rem_shift - {1'b0, bps_reg}) : rem_shift;
    end

    // Root directory sectors round up; a zero sector size gives none.
    always_comb
    begin
        if (bps_reg == 13'd0)
        begin
            root_secs = 22'd0;
        end
        else
        begin
            root_secs = {1'b0, quot_reg} + 22'(rem_reg != 14'd0);
        end
        sum_next = 22'(res_reg) + (22'(spf_reg) * 22'(copies_reg)) + root_secs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= G_LOAD;
            bps_reg    <= 13'd512;
            spc_reg    <= 8'd1;
            res_reg    <= 16'd1;
            spf_reg    <= 16'd9;
            copies_reg <= 3'd2;
            rec_reg    <= 16'd224;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_SECTOR:    bps_reg    <= cfg_data[12:0];
                CFG_SECTORS_PER_CLUSTER: spc_reg    <= cfg_data[7:0];
                CFG_RESERVED_SECTORS:    res_reg    <= cfg_data;
                CFG_SECTORS_PER_FAT:     spf_reg    <= cfg_data;
                CFG_FAT_COPIES:          copies_reg <= cfg_data[2:0];
                CFG_ROOT_ENTRY_COUNT:    rec_reg    <= cfg_data;
                default:                 ;
            endcase
            state_reg <= G_LOAD;
        end
        else
        begin
            unique case (state_reg)
                G_LOAD:
                begin
                    rem_reg   <= 14'd0;
                    quot_reg  <= {rec_reg, 5'd0};
                    cnt_reg   <= 5'd0;
                    state_reg <= G_DIV;
                end
                G_DIV:
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[NUM_W-2:0], qbit};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                    begin
                        state_reg <= G_SUM;
                    end
                end
                G_SUM:
                begin
                    sum_reg   <= sum_next;
                    state_reg <= G_MUL;
                end
                G_MUL:
                begin
                    data_start_reg    <= 32'(bps_reg) * 32'(sum_reg);
                    cluster_bytes_reg <= 21'(bps_reg) * 21'(spc_reg);
                    state_reg         <= G_IDLE;
                end
                G_IDLE:
                begin
                    state_reg <= G_IDLE;
                end
                default:
                begin
                    state_reg <= G_LOAD;
                end
            endcase
        end
    end

    assign busy               = (state_reg != G_IDLE);
    assign geom.cluster_bytes = cluster_bytes_reg;
    assign geom.data_start    = data_start_reg;

endmodule

// File: src/fcc_front.sv
// ----------------------------------------------------------------------------
// FAT12 front end
// Accepts input transactions and classifies each one into a command.
// ----------------------------------------------------------------------------
module fcc_front
    import fcc_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [12:0] table_byte_index,
    input  logic [7:0]  table_byte_value,
    input  logic [11:0] cluster,
    input  logic        busy,
    input  logic        q_ready,
    output logic        push,
    output cmd_t        cmd
);

    always_comb
    begin
        priority if (!action)
        begin
            cmd.status = ST_WRITE;
        end
        else if (cluster < CLUSTER_FIRST)
        begin
            cmd.status = ST_RESERVED;
        end
        else if (cluster >= CLUSTER_END_FIRST)
        begin
            cmd.status = ST_END;
        end
        else if (cluster == CLUSTER_BAD)
        begin
            cmd.status = ST_BAD;
        end
        else
        begin
            cmd.status = ST_DATA;
        end
        cmd.idx    = table_byte_index;
        cmd.val    = table_byte_value;
        // The entry starts at byte cluster * 3 / 2.
        cmd.pos    = 13'(cluster) + 13'(cluster >> 1);
        cmd.odd    = cluster[0];
        cmd.offset = cluster - CLUSTER_FIRST;
    end

    assign in_ready = q_ready && !busy;
    assign push     = in_valid && in_ready;

endmodule

// File: src/fcc_queue.sv
// ----------------------------------------------------------------------------
// FAT12 command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fcc_queue
    import fcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic q_ready,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign q_ready    = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

endmodule

// File: src/fcc_back.sv
// ----------------------------------------------------------------------------
// FAT12 back end
// Executes commands: table byte writes, entry reads from two byte banks and
// the cluster address computation, with a registered result stage.
// ----------------------------------------------------------------------------
module fcc_back
    import fcc_pkg::*;
#(
    parameter int FAT_BYTES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    input  geom_t       geom,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] cluster_address,
    output logic [11:0] next_cluster
);

    // Even table bytes live in one bank, odd ones in the other, so the two
    // bytes of an entry are always read from different banks.
    localparam int BANK_DEPTH = (FAT_BYTES + 1) / 2;
    localparam int BW         = $clog2(BANK_DEPTH);

    logic          s1_valid_reg;
    logic [2:0]    s1_status_reg;
    logic          s1_odd_reg;
    logic          s1_swap_reg;
    logic          s1_lo_ok_reg;
    logic          s1_hi_ok_reg;
    logic [31:0]   s1_product_reg;

    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [31:0]   addr_reg;
    logic [11:0]   next_reg;

    logic          out_load;
    logic          s1_free;
    logic          wr_en;
    logic [31:0]   widx_half;
    logic [31:0]   pos_half;
    logic [31:0]   even_raddr_full;
    logic          lo_ok;
    logic          hi_ok;
    logic [7:0]    even_rdata;
    logic [7:0]    odd_rdata;
    logic [7:0]    lo_byte;
    logic [7:0]    hi_byte;
    logic [15:0]   pair;
    logic [11:0]   entry;

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free  = !s1_valid_reg || out_load;
    assign pop      = head_valid && s1_free;

    assign wr_en = pop && (head_cmd.status == ST_WRITE)
                   && (32'(head_cmd.idx) < FAT_BYTES);
    assign widx_half       = 32'(head_cmd.idx >> 1);
    assign pos_half        = 32'(head_cmd.pos >> 1);
    assign even_raddr_full = pos_half + 32'(head_cmd.pos[0]);
    assign lo_ok           = 32'(head_cmd.pos) < FAT_BYTES;
    assign hi_ok           = (32'(head_cmd.pos) + 32'd1) < FAT_BYTES;

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (wr_en && !head_cmd.idx[0]),
        .waddr (widx_half[BW-1:0]),
        .wdata (head_cmd.val),
        .re    (pop),
        .raddr (even_raddr_full[BW-1:0]),
        .rdata (even_rdata)
    );

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (wr_en && head_cmd.idx[0]),
        .waddr (widx_half[BW-1:0]),
        .wdata (head_cmd.val),
        .re    (pop),
        .raddr (pos_half[BW-1:0]),
        .rdata (odd_rdata)
    );

    // An odd byte position puts the low byte in the odd bank.
    always_comb
    begin
        lo_byte = s1_swap_reg ? odd_rdata : even_rdata;
        hi_byte = s1_swap_reg ? even_rdata : odd_rdata;
        pair    = {(s1_hi_ok_reg ? hi_byte : 8'd0), (s1_lo_ok_reg ? lo_byte : 8'd0)};
        entry   = s1_odd_reg ? pair[15:4] : pair[11:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_status_reg  <= head_cmd.status;
            s1_odd_reg     <= head_cmd.odd;
            s1_swap_reg    <= head_cmd.pos[0];
            s1_lo_ok_reg   <= lo_ok;
            s1_hi_ok_reg   <= hi_ok;
            s1_product_reg <= 32'(head_cmd.offset) * 32'(geom.cluster_bytes);
        end
        if (out_load)
        begin
            status_reg <= s1_status_reg;
            if (s1_status_reg == ST_DATA)
            begin
                addr_reg <= geom.data_start + s1_product_reg;
                next_reg <= entry;
            end
            else
            begin
                addr_reg <= 32'd0;
                next_reg <= 12'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= pop;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign cluster_address = addr_reg;
    assign next_cluster    = next_reg;

endmodule

// File: tb/sv/fat12_cluster_chain_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT12 cluster chain step testbench
// Drives table byte writes and cluster follows through the valid/ready
// channels under several volume geometries and idle patterns. A local copy of
// the table and the geometry predicts every result, and each result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_step_test;
    import fcc_pkg::*;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_FOLLOW = 1'b1;

    localparam int FAT_BYTES          = 8192;
    localparam logic [11:0] LAST_DATA_CLUSTER = CLUSTER_BAD - 12'd1;
    // Bytes that entries of data clusters can ever touch.
    localparam int TABLE_SPAN = (int'(LAST_DATA_CLUSTER) * 3) / 2 + 2;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
        logic [11:0] next;
    } chain_result_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   action = ACT_WRITE;
    logic [12:0]            table_byte_index = '0;
    logic [7:0]             table_byte_value = '0;
    logic [11:0]            cluster = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [2:0]             status;
    logic [31:0]            cluster_address;
    logic [11:0]            next_cluster;

    // Local image of the table and of the volume geometry.
    logic [7:0]        fat_img [FAT_BYTES];
    bit                written [FAT_BYTES];
    longint unsigned   geo_bps = 512;
    longint unsigned   geo_spc = 1;
    longint unsigned   geo_res = 1;
    longint unsigned   geo_spf = 9;
    longint unsigned   geo_copies = 2;
    longint unsigned   geo_root = 224;

    chain_result_t results_due[$];
    int            error_count = 0;
    int            sent_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_left = 0;

    fat12_cluster_chain_step i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .table_byte_index (table_byte_index),
        .table_byte_value (table_byte_value),
        .cluster          (cluster),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .cluster_address  (cluster_address),
        .next_cluster     (next_cluster)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [31:0] data_address(input logic [11:0] cl);
        longint unsigned root_secs;
        longint unsigned start;
        longint unsigned c;
        root_secs = 0;
        c = cl;
        if (geo_bps != 0)
            root_secs = (geo_root * 32 + geo_bps - 1) / geo_bps;
        start = geo_bps * (geo_res + geo_spf * geo_copies + root_secs);
        return 32'(start + (c - 2) * geo_bps * geo_spc);
    endfunction

    function automatic logic [11:0] table_entry(input logic [11:0] cl);
        int          pos;
        logic [15:0] pair;
        pos = (int'(cl) * 3) / 2;
        pair = {fat_img[pos + 1], fat_img[pos]};
        return cl[0] ? pair[15:4] : pair[11:0];
    endfunction

    function automatic bit is_data_cluster(input logic [11:0] cl);
        return cl >= CLUSTER_FIRST && cl <= LAST_DATA_CLUSTER;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Offers one transaction, waits for acceptance and records its outcome.
    // Valid is only lowered by a later idle cycle, so it never drops and
    // rises again within one time step.
    task automatic send_item(input logic act, input logic [12:0] idx,
                             input logic [7:0] val, input logic [11:0] cl);
        chain_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        table_byte_index <= idx;
        table_byte_value <= val;
        cluster <= cl;
        do @(posedge clk); while (!in_ready);
        r = '0;
        if (act == ACT_WRITE)
        begin
            fat_img[idx] = val;
            written[idx] = 1'b1;
            r.status = ST_WRITE;
        end
        else if (cl < CLUSTER_FIRST)
            r.status = ST_RESERVED;
        else if (cl >= CLUSTER_END_FIRST)
            r.status = ST_END;
        else if (cl == CLUSTER_BAD)
            r.status = ST_BAD;
        else
        begin
            r.status = ST_DATA;
            r.address = data_address(cl);
            r.next = table_entry(cl);
        end
        results_due.insert(results_due.size(), r);
        sent_count++;
    endtask

    task automatic write_byte(input int idx, input logic [7:0] val);
        send_item(ACT_WRITE, 13'(idx), val, 12'($urandom));
    endtask

    // Makes sure both table bytes behind a data cluster hold known values, then follows the cluster.
    task automatic follow_cluster(input logic [11:0] cl);
        int pos;
        pos = (int'(cl) * 3) / 2;
        if (is_data_cluster(cl))
        begin
            if (!written[pos])
                write_byte(pos, 8'($urandom));
            if (!written[pos + 1])
                write_byte(pos + 1, 8'($urandom));
        end
        send_item(ACT_FOLLOW, 13'($urandom), 8'($urandom), cl);
    endtask

    // Writes the two bytes that hold one entry, keeping the neighbor's nibble.
    // A byte that was never written gets a random neighbor nibble.
    task automatic set_entry(input logic [11:0] cl, input logic [11:0] value);
        int          pos;
        logic [15:0] pair;
        pos = (int'(cl) * 3) / 2;
        if (!written[pos])
            fat_img[pos] = 8'($urandom);
        if (!written[pos + 1])
            fat_img[pos + 1] = 8'($urandom);
        pair = {fat_img[pos + 1], fat_img[pos]};
        if (cl[0])
            pair[15:4] = value;
        else
            pair[11:0] = value;
        write_byte(pos, pair[7:0]);
        write_byte(pos + 1, pair[15:8]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic set_geometry(input int bps, input int spc, input int res,
                                input int spf, input int copies, input int rec);
        wait_idle();
        write_reg(CFG_BYTES_PER_SECTOR, bps);
        write_reg(CFG_SECTORS_PER_CLUSTER, spc);
        write_reg(CFG_RESERVED_SECTORS, res);
        write_reg(CFG_SECTORS_PER_FAT, spf);
        write_reg(CFG_FAT_COPIES, copies);
        write_reg(CFG_ROOT_ENTRY_COUNT, rec);
        cfg_we <= 1'b0;
        geo_bps = bps & 16'h1FFF;
        geo_spc = spc & 8'hFF;
        geo_res = res & 16'hFFFF;
        geo_spf = spf & 16'hFFFF;
        geo_copies = copies & 3'h7;
        geo_root = rec & 16'hFFFF;
    endtask

    function automatic int pick16();
        case ($urandom_range(5))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic random_geometry();
        int bps;
        int spc;
        case ($urandom_range(9))
            0: bps = 0;
            1: bps = 1;
            2: bps = 4096;
            3, 4: bps = 512;
            default: bps = $urandom_range(1, 4096);
        endcase
        case ($urandom_range(3))
            0: spc = $urandom_range(1) ? 1 : 128;
            default: spc = $urandom_range(1, 128);
        endcase
        set_geometry(bps, spc, pick16(), pick16(), $urandom_range(1, 4), pick16());
    endtask

    // Builds a short chain of entries and walks it the way a file reader would.
    task automatic build_and_walk_chain();
        logic [11:0] hops[8];
        logic [11:0] cur;
        int          len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            hops[i] = 12'($urandom_range(CLUSTER_FIRST, LAST_DATA_CLUSTER));
        for (int i = 0; i < len - 1; i++)
            set_entry(hops[i], hops[i + 1]);
        if ($urandom_range(4) == 0)
            set_entry(hops[len - 1], CLUSTER_BAD);
        else
            set_entry(hops[len - 1], CLUSTER_END_FIRST + 12'($urandom_range(7)));
        cur = hops[0];
        for (int step = 0; step < len + 2; step++)
        begin
            follow_cluster(cur);
            if (!is_data_cluster(cur))
                break;
            cur = table_entry(cur);
        end
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            build_and_walk_chain();
        else if (pick < 55)
            follow_cluster(12'($urandom_range(CLUSTER_FIRST, LAST_DATA_CLUSTER)));
        else if (pick < 65)
        begin
            if ($urandom_range(2) == 0)
                follow_cluster(12'($urandom_range(1)));
            else
                follow_cluster(12'($urandom_range(CLUSTER_BAD, 12'hFFF)));
        end
        else if ($urandom_range(99) < 85)
            write_byte($urandom_range(TABLE_SPAN - 1), 8'($urandom));
        else
            write_byte($urandom_range(TABLE_SPAN, FAT_BYTES - 1), 8'($urandom));
    endtask

    // Receiver: random or held-off ready, and the result check.
    always @(posedge clk)
    begin
        chain_result_t r;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
                report_mismatch("result arrived with no transaction outstanding");
            else
            begin
                r = results_due.pop_front();
                if (status !== r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, r.status));
                if (cluster_address !== r.address)
                    report_mismatch($sformatf("cluster_address %h, expected %h",
                                              cluster_address, r.address));
                if (next_cluster !== r.next)
                    report_mismatch($sformatf("next_cluster %h, expected %h",
                                              next_cluster, r.next));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_reset_defaults();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_byte(0, 8'h00);
        write_byte(FAT_BYTES - 1, 8'hFF);
        write_byte(13'h0AAA, 8'hAA);
        write_byte(13'h1555, 8'h55);
        follow_cluster(12'd0);
        follow_cluster(12'd1);
        follow_cluster(CLUSTER_BAD);
        follow_cluster(CLUSTER_END_FIRST);
        follow_cluster(12'hFFF);
        set_entry(12'd2, 12'hFFF);
        set_entry(12'd3, 12'h003);
        set_entry(LAST_DATA_CLUSTER, 12'hABC);
        follow_cluster(12'd2);
        follow_cluster(12'd3);
        follow_cluster(LAST_DATA_CLUSTER);
        follow_cluster(12'hAAA);
        follow_cluster(12'h555);
    endtask

    task automatic test_geometry_extremes();
        set_geometry(4096, 128, 65535, 65535, 4, 65535);
        follow_cluster(12'd2);
        follow_cluster(LAST_DATA_CLUSTER);
        set_geometry(1, 1, 0, 0, 1, 0);
        follow_cluster(12'd2);
        follow_cluster(LAST_DATA_CLUSTER);
        // A zero sector size collapses every address to zero.
        set_geometry(0, 1, 1, 9, 2, 224);
        follow_cluster(12'd3);
        follow_cluster(LAST_DATA_CLUSTER);
        // The root directory count rounds up to a whole sector here.
        set_geometry(3, 7, 5, 11, 3, 17);
        follow_cluster(12'd2);
        follow_cluster(12'd3);
    endtask

    task automatic test_output_stall();
        set_geometry(512, 4, 32, 9, 2, 512);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 48; i++)
            random_item();
        wait_idle();
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int n);
        int target;
        int next_cfg;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = sent_count + n;
        next_cfg = sent_count;
        while (sent_count < target)
        begin
            if (sent_count >= next_cfg)
            begin
                random_geometry();
                next_cfg = sent_count + 150;
            end
            random_item();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(24, 61, 400);
        run_random_phase(61, 24, 400);
        run_random_phase(0, 0, 400);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_geometry_extremes();
        test_output_stall();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/fcc_pkg.sv
src/fcc_ram.sv
src/fcc_geom.sv
src/fcc_front.sv
src/fcc_queue.sv
src/fcc_back.sv
src/fat12_cluster_chain_step.sv
tb/sv/fat12_cluster_chain_step_test.sv
